/* sv/bvag_pkg.sv */
// Package for the buffer voice activity gate: sizes, codes, register map and
// the structs passed between the front, the summary queue and the back.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bvag_pkg;

	localparam int MAX_BUFFER_SAMPLES = 4096;
	localparam int SAMPLE_STEP        = 4;

	localparam int POS_W   = $clog2(MAX_BUFFER_SAMPLES + 1);
	localparam int PHASE_W = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
	localparam int HEAD_W  = 18;
	localparam int CNT_W   = 15;
	localparam int BUF_W   = 16;
	localparam int HELD_W  = 10;
	localparam int ADDR_W  = 5;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_END   = 2'd1,
		EV_FLUSH = 2'd2
	} event_t;

	typedef enum logic [2:0] {
		REG_NOISE_LEVEL   = 3'd0,
		REG_HYSTERESIS    = 3'd1,
		REG_MIN_SIGNAL    = 3'd2,
		REG_FLUSH_LIMIT   = 3'd3,
		REG_PREROLL_EXTRA = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]     noise_level;
		logic [7:0]      hysteresis_count;
		logic [CNT_W-1:0] min_signal_samples;
		logic [HELD_W-1:0] flush_limit;
		logic [7:0]      preroll_extra;
	} cfg_t;

	typedef struct packed {
		logic [15:0]      peak;
		logic [CNT_W-1:0] count;
	} summary_t;

	typedef struct packed {
		logic              buffer_has_signal;
		logic [15:0]       peak;
		logic [CNT_W-1:0]  signal_count;
		logic              in_speech;
		event_t            event_res;
		logic [HELD_W-1:0] buffers_held;
	} result_t;

endpackage
`default_nettype wire

/* sv/bvag_front.sv */
// Front of the gate: per-sample magnitude, loud count and head sum; emits one
// buffer summary on each last sample. Depends on bvag_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bvag_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic signed [15:0]  sample,
	input  wire logic                last_in_buffer,
	input  wire logic [15:0]         noise_level,
	output bvag_pkg::summary_t       sum_data,
	output logic                     sum_push
);
	import bvag_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0]   loud_q;
	logic [HEAD_W-1:0]  head_q;

	logic [15:0]        mag;
	logic               in_window;
	logic               loud;
	logic [HEAD_W-1:0]  head_n;
	logic [CNT_W-1:0]   loud_n;

	always_comb begin
		mag       = sample[15] ? (~sample + 16'd1) : sample;
		in_window = (pos_q < POS_W'(MAX_BUFFER_SAMPLES));
		loud      = in_window && (phase_q == '0) && (mag > noise_level);
		head_n    = (pos_q < POS_W'(4)) ? head_q + HEAD_W'(mag) : head_q;
		loud_n    = (loud && (loud_q != '1)) ? loud_q + CNT_W'(1) : loud_q;
		sum_push  = accept && last_in_buffer;
		sum_data.peak  = head_n[17:2];
		sum_data.count = loud_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= '0;
			loud_q  <= '0;
			head_q  <= '0;
		end else if (accept) begin
			if (last_in_buffer) begin
				pos_q   <= '0;
				phase_q <= '0;
				loud_q  <= '0;
				head_q  <= '0;
			end else begin
				head_q <= head_n;
				loud_q <= loud_n;
				if (in_window) begin
					pos_q   <= pos_q + POS_W'(1);
					phase_q <= (phase_q == PHASE_W'(SAMPLE_STEP - 1)) ? '0
					           : phase_q + PHASE_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

/* sv/bvag_sumq.sv */
// Two-entry queue of buffer summaries between front and back.
// Depends on bvag_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bvag_sumq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  bvag_pkg::summary_t push_data,
	input  wire logic          pop,
	output bvag_pkg::summary_t pop_data,
	output logic               full,
	output logic               empty
);
	import bvag_pkg::*;

	summary_t    mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

/* sv/bvag_back.sv */
// Back of the gate: classify each buffer summary, run the silence/speech
// hysteresis and held-buffer accounting, queue results. Depends on bvag_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bvag_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  bvag_pkg::cfg_t     cfg,
	input  wire logic          sum_valid,
	input  bvag_pkg::summary_t sum_data,
	output logic               sum_pop,
	input  wire logic          res_pop,
	output bvag_pkg::result_t  res_data,
	output logic               res_empty
);
	import bvag_pkg::*;

	logic [BUF_W-1:0]  noise_q;
	logic [BUF_W-1:0]  sig_q;
	logic              speech_q;
	logic [HELD_W-1:0] held_q;

	result_t     res_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	logic              has_sig;
	logic [BUF_W-1:0]  noise_n;
	logic [BUF_W-1:0]  sig_n;
	logic              speech_n;
	logic [HELD_W-1:0] held_inc;
	logic [HELD_W-1:0] held_n;
	logic [8:0]        keep;
	logic [HELD_W-1:0] report;
	event_t            ev;
	result_t           res_n;
	logic              res_push;

	always_comb begin
		has_sig  = (sum_data.count >= cfg.min_signal_samples);
		noise_n  = noise_q;
		sig_n    = sig_q;
		if (has_sig) begin
			if (sig_q != '1) sig_n = sig_q + BUF_W'(1);
		end else begin
			if (noise_q != '1) noise_n = noise_q + BUF_W'(1);
		end
		held_inc = (held_q != '1) ? held_q + HELD_W'(1) : held_q;
		keep     = {1'b0, cfg.hysteresis_count} + {1'b0, cfg.preroll_extra};
		speech_n = speech_q;
		held_n   = held_inc;
		ev       = EV_NONE;
		report   = held_inc;
		if (speech_q) begin
			// Enough noise buffers end the utterance and release everything held.
			if (noise_n > BUF_W'(cfg.hysteresis_count)) begin
				sig_n    = '0;
				speech_n = 1'b0;
				ev       = EV_END;
				held_n   = '0;
			end
		end else begin
			if (sig_n > BUF_W'(cfg.hysteresis_count)) begin
				noise_n  = '0;
				speech_n = 1'b1;
			end
			// Trim the pre-roll while silent, also on the switching buffer.
			if (held_inc > HELD_W'(keep)) held_n = HELD_W'(keep);
		end
		if (ev == EV_NONE) begin
			if (held_n > cfg.flush_limit) begin
				ev     = EV_FLUSH;
				report = held_n;
				held_n = '0;
			end else begin
				report = held_n;
			end
		end
		res_n.buffer_has_signal = has_sig;
		res_n.peak              = sum_data.peak;
		res_n.signal_count      = sum_data.count;
		res_n.in_speech         = speech_n;
		res_n.event_res         = ev;
		res_n.buffers_held      = report;

		sum_pop  = sum_valid && (cnt_q != 2'd2);
		res_push = sum_pop;
		res_empty = (cnt_q == 2'd0);
		res_data  = res_q[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q  <= '0;
			sig_q    <= '0;
			speech_q <= 1'b0;
			held_q   <= '0;
		end else if (sum_pop) begin
			noise_q  <= noise_n;
			sig_q    <= sig_n;
			speech_q <= speech_n;
			held_q   <= held_n;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[wr_q] <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push) wr_q <= ~wr_q;
			if (res_pop && !res_empty) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(res_push) - 2'(res_pop && !res_empty);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_end_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_n.event_res == EV_END) |-> !res_n.in_speech && speech_q)
		else $error("utterance end reported outside speech");

	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_n.event_res != EV_NONE) |=> held_q == '0)
		else $error("held count not cleared after event");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!sum_pop |=> $stable(speech_q) && $stable(held_q))
		else $error("gate state changed without a summary");

endmodule
`default_nettype wire

/* sv/buffer_voice_activity_gate.sv */
// Top level of the buffer voice activity gate: register file, front, summary
// queue and back. Depends on bvag_pkg, bvag_front, bvag_sumq, bvag_back.
`timescale 1ns / 1ps
`default_nettype none
// The gate takes one audio sample per clock while full is low, through a
// queue-style input (push/full), and delivers one result per buffer through
// a queue-style output (empty/pop). The front classifies each sample in the
// cycle it is accepted (magnitude, loud test on every SAMPLE_STEP-th position,
// head sum of the first four) and on the last sample writes a buffer summary
// into a two-entry queue. The back takes one summary per cycle while the
// output queue has room, runs the silence/speech hysteresis and held-buffer
// trim and flush, and writes the result into a two-entry output queue; a
// result shows once registered there. full rises only when both queues are
// full because results are not popped. Registers sit at byte addresses 0,
// 4, 8, 12, 16; the user must write them only while the gate is idle, and
// the block does not enforce this. pready is always high.
module buffer_voice_activity_gate (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// sample request side
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] sample,
	input  wire logic               last_in_buffer,
	// result side
	output logic                    empty,
	input  wire logic               pop,
	output logic                    buffer_has_signal,
	output logic [15:0]             peak,
	output logic [14:0]             signal_count,
	output logic                    in_speech,
	output logic [1:0]              event_res,
	output logic [9:0]              buffers_held,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import bvag_pkg::*;

	cfg_t      cfg_q;
	reg_idx_t  reg_idx;
	logic      cfg_wr;
	logic      accept;

	summary_t  front_sum;
	logic      front_push;
	summary_t  q_sum;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	result_t   res;

	// Register file: decode the word index, write on the access phase.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_level        <= 16'd3000;
			cfg_q.hysteresis_count   <= 8'd4;
			cfg_q.min_signal_samples <= 15'd20;
			cfg_q.flush_limit        <= 10'd300;
			cfg_q.preroll_extra      <= 8'd4;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NOISE_LEVEL:   cfg_q.noise_level        <= pwdata[15:0];
				REG_HYSTERESIS:    cfg_q.hysteresis_count   <= pwdata[7:0];
				REG_MIN_SIGNAL:    cfg_q.min_signal_samples <= pwdata[14:0];
				REG_FLUSH_LIMIT:   cfg_q.flush_limit        <= pwdata[9:0];
				REG_PREROLL_EXTRA: cfg_q.preroll_extra      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NOISE_LEVEL:   prdata = {16'd0, cfg_q.noise_level};
			REG_HYSTERESIS:    prdata = {24'd0, cfg_q.hysteresis_count};
			REG_MIN_SIGNAL:    prdata = {17'd0, cfg_q.min_signal_samples};
			REG_FLUSH_LIMIT:   prdata = {22'd0, cfg_q.flush_limit};
			REG_PREROLL_EXTRA: prdata = {24'd0, cfg_q.preroll_extra};
			default:           prdata = 32'd0;
		endcase
	end

	// Hold off new samples while the summary queue has no room.
	assign full   = q_full;
	assign accept = push && !q_full;

	bvag_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.sample         (sample),
		.last_in_buffer (last_in_buffer),
		.noise_level    (cfg_q.noise_level),
		.sum_data       (front_sum),
		.sum_push       (front_push)
	);

	bvag_sumq u_sumq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_data (front_sum),
		.pop       (q_pop),
		.pop_data  (q_sum),
		.full      (q_full),
		.empty     (q_empty)
	);

	bvag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sum_valid (!q_empty),
		.sum_data  (q_sum),
		.sum_pop   (q_pop),
		.res_pop   (pop),
		.res_data  (res),
		.res_empty (empty)
	);

	// Unpack the oldest waiting result onto the ports.
	assign buffer_has_signal = res.buffer_has_signal;
	assign peak              = res.peak;
	assign signal_count      = res.signal_count;
	assign in_speech         = res.in_speech;
	assign event_res         = res.event_res;
	assign buffers_held      = res.buffers_held;

endmodule
`default_nettype wire
